// ----- rtl/rshm_pkg.sv -----
// ----------------------------------------------------------------------------
// Range sensor health monitor package
// Shared types and constants for the front part, queue and back part.
// ----------------------------------------------------------------------------
package rshm_pkg;

    typedef enum logic [2:0] {
        REQ_MEAS    = 3'd0,
        REQ_XFAIL   = 3'd1,
        REQ_FAULT   = 3'd2,
        REQ_RECOVER = 3'd3,
        REQ_PAUSE   = 3'd4,
        REQ_QUERY   = 3'd5,
        REQ_RESTART = 3'd6,
        REQ_NONE    = 3'd7
    } req_t;

    localparam logic [2:0] H_STARTING   = 3'd0;
    localparam logic [2:0] H_HEALTHY    = 3'd1;
    localparam logic [2:0] H_DEGRADED   = 3'd2;
    localparam logic [2:0] H_FAULTED    = 3'd3;
    localparam logic [2:0] H_RECOVERING = 3'd4;

    localparam logic [2:0] CFG_MAX_DIST  = 3'd0;
    localparam logic [2:0] CFG_GRACE     = 3'd1;
    localparam logic [2:0] CFG_FRESH_TO  = 3'd2;
    localparam logic [2:0] CFG_FRESH_MIN = 3'd3;
    localparam logic [2:0] CFG_USE_MIN   = 3'd4;
    localparam logic [2:0] CFG_STREAK    = 3'd5;
    localparam logic [2:0] CFG_REC_AGE   = 3'd6;
    localparam logic [2:0] CFG_OUT_AGE   = 3'd7;

    // Classified request travelling from the front part to the back part.
    typedef struct packed {
        req_t        req;
        logic [31:0] now;
        logic [31:0] stamp;
        logic        meas_ok;
        logic [15:0] dist_mm;  // already clamped
        logic [31:0] paused;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_APPLY,
        BK_FILT,
        BK_DIV,
        BK_DONE
    } bk_state_t;

endpackage

// ----- rtl/rshm_front.sv -----
// ----------------------------------------------------------------------------
// Range sensor health monitor front part
// Accepts requests, clamps distance, checks status and forms a command.
// ----------------------------------------------------------------------------
module rshm_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [31:0]        s_now_ms,
    input  logic [31:0]        s_sensor_time_ms,
    input  logic [15:0]        s_meas_status,
    input  logic [31:0]        s_raw_distance_mm,
    input  logic [31:0]        s_paused_ms,
    input  logic [15:0]        max_distance,
    output logic               q_push,
    output rshm_pkg::cmd_t     q_data,
    input  logic               q_full
);
    rshm_pkg::cmd_t cmd_reg;
    logic           cmd_valid_reg;
    logic [15:0]    clamp;

    assign s_ready = !cmd_valid_reg || !q_full;
    assign clamp   = (s_raw_distance_mm > {16'd0, max_distance}) ? max_distance
                     : s_raw_distance_mm[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else if (s_ready) begin
            cmd_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg.req     <= rshm_pkg::req_t'(s_req_type);
            cmd_reg.now     <= s_now_ms;
            cmd_reg.stamp   <= s_sensor_time_ms;
            cmd_reg.meas_ok <= (s_meas_status == 16'd1) && (s_raw_distance_mm != 32'd0);
            cmd_reg.dist_mm <= clamp;
            cmd_reg.paused  <= s_paused_ms;
        end
    end

    assign q_push = cmd_valid_reg && !q_full;
    assign q_data = cmd_reg;
endmodule

// ----- rtl/rshm_queue.sv -----
// ----------------------------------------------------------------------------
// Range sensor health monitor command queue
// Two-entry queue between the front part and the back part.
// ----------------------------------------------------------------------------
module rshm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rshm_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output rshm_pkg::cmd_t pop_data
);
    rshm_pkg::cmd_t mem_reg [2];
    logic           wr_reg, rd_reg;
    logic [1:0]     cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wr_reg] <= push_data;
    end
endmodule

// ----- rtl/rshm_back.sv -----
// ----------------------------------------------------------------------------
// Range sensor health monitor back part
// Applies a command to the monitor state, walks the filter, and forms results.
// ----------------------------------------------------------------------------
module rshm_back #(
    parameter int WINDOW_SIZE = 16,
    parameter int FILTER_SIZE = 5
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_not_empty,
    input  rshm_pkg::cmd_t q_data,
    output logic           q_pop,
    input  logic [31:0]    grace,
    input  logic [31:0]    fresh_to,
    input  logic [4:0]     fresh_min,
    input  logic [4:0]     use_min,
    input  logic [7:0]     streak_min,
    input  logic [31:0]    rec_age,
    input  logic [31:0]    out_age,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_fresh_frame,
    output logic           m_sensor_restarted,
    output logic           m_measurement_ok,
    output logic           m_usable,
    output logic [15:0]    m_filtered_mm,
    output logic [2:0]     m_health_state,
    output logic           m_declare_fault,
    output logic           m_recovery_ok,
    output logic           m_output_ok,
    output logic [6:0]     m_fresh_rate_pct,
    output logic [6:0]     m_usable_rate_pct,
    output logic [7:0]     m_usable_run
);
    localparam int FW = $clog2(WINDOW_SIZE + 1);
    localparam int PW = $clog2(FILTER_SIZE);
    localparam int IW = $clog2(FILTER_SIZE + 1);
    localparam int SW = 16 + IW;
    localparam int DW = 16 + IW;
    localparam int RW = 7 + FW;   // ones * 100 fits here
    // The trimmed sum is divided by FILTER_SIZE-2 through a rounded-up
    // reciprocal; KS extra fraction bits keep the quotient exact for SW bits.
    localparam int TD = FILTER_SIZE - 2;
    localparam int KS = DW + $clog2(TD);
    localparam logic [KS:0] RECIP =
        (KS+1)'(((64'd1 << KS) + 64'(TD) - 64'd1) / 64'(TD));

    rshm_pkg::bk_state_t st_reg, st_next;
    rshm_pkg::cmd_t      c_reg;

    logic [2:0]              health_reg;
    logic [31:0]             start_reg, lfresh_reg, luse_reg, lstamp_reg;
    logic                    hfresh_reg, huse_reg, hstamp_reg, latch_reg, primed_reg;
    logic [WINDOW_SIZE-1:0]  fhist_reg, uhist_reg;
    logic [FW-1:0]           fill_reg;
    logic [7:0]              streak_reg;
    logic [15:0]             fstore_reg [FILTER_SIZE];
    logic [PW-1:0]           fpos_reg;
    logic [15:0]             fval_reg;
    logic                    o_fresh_reg, o_rst_reg, o_ok_reg, o_use_reg;
    logic                    o_valid_reg;

    // filter walk
    logic [IW-1:0]  idx_reg;
    logic [15:0]    mn_reg, mx_reg;
    logic [SW-1:0]  sum_reg;
    // restoring divider for the rates: quotient bits, one per cycle
    logic [DW-1:0]  num_reg, quo_reg;
    logic [DW-1:0]  rem_reg;
    logic [5:0]     dcnt_reg;
    logic [1:0]     dsel_reg;  // 1 fresh rate, 2 usable rate
    logic [RW-1:0]  rnum_u_reg;
    logic [6:0]     fr_reg, ur_reg;

    logic [FW-1:0]   fones, uones;
    logic [DW-1:0]   div_den;
    logic [DW:0]     rem_sh;
    logic [SW-1:0]   trim;
    logic [DW+KS:0]  trim_prod;

    always_comb begin
        fones = '0;
        uones = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            fones = fones + FW'(fhist_reg[i]);
            uones = uones + FW'(uhist_reg[i]);
        end
    end

    assign div_den   = DW'(fill_reg);
    assign rem_sh    = {rem_reg, num_reg[DW-1]};
    assign trim      = sum_reg - SW'(mn_reg) - SW'(mx_reg);
    assign trim_prod = (DW+KS+1)'(trim) * (DW+KS+1)'(RECIP);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            rshm_pkg::BK_IDLE:  if (q_not_empty && !o_valid_reg) st_next = rshm_pkg::BK_APPLY;
            rshm_pkg::BK_APPLY: st_next = rshm_pkg::BK_FILT;
            rshm_pkg::BK_FILT:  if (!o_use_reg || idx_reg == IW'(FILTER_SIZE))
                                    st_next = rshm_pkg::BK_DIV;
            rshm_pkg::BK_DIV:   if (dsel_reg == 2'd2 && dcnt_reg == 6'd0)
                                    st_next = rshm_pkg::BK_DONE;
            rshm_pkg::BK_DONE:  st_next = rshm_pkg::BK_IDLE;
            default:            st_next = rshm_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop = (st_reg == rshm_pkg::BK_IDLE) && q_not_empty && !o_valid_reg;
    end

    // Apply-stage helpers
    logic        a_fresh, a_rst, a_use;
    logic [31:0] dback;
    always_comb begin
        a_fresh = 1'b0;
        a_rst   = 1'b0;
        dback   = lstamp_reg - c_reg.stamp;
        if (!hstamp_reg) begin
            a_fresh = 1'b1;
        end else if (c_reg.stamp != lstamp_reg) begin
            a_fresh = 1'b1;
            a_rst   = (c_reg.stamp < lstamp_reg) && !dback[31];
        end
        a_use = a_fresh && c_reg.meas_ok;
    end

    logic [31:0] age_use;
    assign age_use = c_reg.now - luse_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= rshm_pkg::BK_IDLE;
            o_valid_reg <= 1'b0;
            health_reg  <= rshm_pkg::H_STARTING;
            start_reg   <= '0;
            lfresh_reg  <= '0;
            luse_reg    <= '0;
            lstamp_reg  <= '0;
            hfresh_reg  <= 1'b0;
            huse_reg    <= 1'b0;
            hstamp_reg  <= 1'b0;
            latch_reg   <= 1'b0;
            primed_reg  <= 1'b0;
            fhist_reg   <= '0;
            uhist_reg   <= '0;
            fill_reg    <= '0;
            streak_reg  <= '0;
            fpos_reg    <= '0;
            fval_reg    <= '0;
            for (int i = 0; i < FILTER_SIZE; i++) fstore_reg[i] <= '0;
        end else begin
            st_reg <= st_next;
            if (o_valid_reg && m_ready) o_valid_reg <= 1'b0;
            case (st_reg)
                rshm_pkg::BK_IDLE: begin
                    if (q_pop) c_reg <= q_data;
                end
                rshm_pkg::BK_APPLY: begin
                    o_fresh_reg <= 1'b0;
                    o_rst_reg   <= 1'b0;
                    o_ok_reg    <= 1'b0;
                    o_use_reg   <= 1'b0;
                    idx_reg     <= '0;
                    sum_reg     <= '0;
                    mn_reg      <= '1;
                    mx_reg      <= '0;
                    case (c_reg.req)
                        rshm_pkg::REQ_MEAS, rshm_pkg::REQ_XFAIL: begin
                            logic                   f, u, rst, lat;
                            logic [WINDOW_SIZE-1:0] fh, uh;
                            logic [FW-1:0]          fl, fo, uo;
                            f   = (c_reg.req == rshm_pkg::REQ_MEAS) && a_fresh;
                            u   = (c_reg.req == rshm_pkg::REQ_MEAS) && a_use;
                            rst = (c_reg.req == rshm_pkg::REQ_MEAS) && a_rst;
                            lat = latch_reg;
                            fh  = rst ? '0 : fhist_reg;
                            uh  = rst ? '0 : uhist_reg;
                            fl  = rst ? '0 : fill_reg;
                            fh  = {fh[WINDOW_SIZE-2:0], f};
                            uh  = {uh[WINDOW_SIZE-2:0], u};
                            if (fl < FW'(WINDOW_SIZE)) fl = fl + FW'(1);
                            fo = '0;
                            uo = '0;
                            for (int i = 0; i < WINDOW_SIZE; i++) begin
                                fo = fo + FW'(fh[i]);
                                uo = uo + FW'(uh[i]);
                            end
                            fhist_reg <= fh;
                            uhist_reg <= uh;
                            fill_reg  <= fl;
                            if (!u) streak_reg <= '0;
                            else if (rst) streak_reg <= 8'd1;
                            else if (streak_reg != 8'hFF) streak_reg <= streak_reg + 8'd1;
                            if (lat)
                                health_reg <= (fh != '0 || uh != '0) ?
                                    rshm_pkg::H_RECOVERING : rshm_pkg::H_FAULTED;
                            else if (fl < FW'(WINDOW_SIZE))
                                health_reg <= rshm_pkg::H_STARTING;
                            else
                                health_reg <= ({{(5-FW+1){1'b0}}, fo} >= {1'b0, fresh_min}
                                    && {{(5-FW+1){1'b0}}, uo} >= {1'b0, use_min}) ?
                                    rshm_pkg::H_HEALTHY : rshm_pkg::H_DEGRADED;
                            if (c_reg.req == rshm_pkg::REQ_MEAS) begin
                                o_fresh_reg <= f;
                                o_rst_reg   <= rst;
                                o_ok_reg    <= c_reg.meas_ok;
                                o_use_reg   <= u;
                                hstamp_reg  <= 1'b1;
                                lstamp_reg  <= c_reg.stamp;
                                if (rst) begin
                                    start_reg  <= c_reg.now;
                                    hfresh_reg <= 1'b0;
                                    huse_reg   <= 1'b0;
                                    fpos_reg   <= '0;
                                    fval_reg   <= '0;
                                    primed_reg <= 1'b0;
                                    for (int i = 0; i < FILTER_SIZE; i++)
                                        fstore_reg[i] <= '0;
                                end
                                if (f) begin
                                    lfresh_reg <= c_reg.now;
                                    hfresh_reg <= 1'b1;
                                end
                                if (u) begin
                                    luse_reg <= c_reg.now;
                                    huse_reg <= 1'b1;
                                    primed_reg <= 1'b1;
                                    if (!primed_reg || rst) begin
                                        for (int i = 0; i < FILTER_SIZE; i++)
                                            fstore_reg[i] <= c_reg.dist_mm;
                                        fpos_reg <= '0;
                                    end else begin
                                        fstore_reg[fpos_reg] <= c_reg.dist_mm;
                                        fpos_reg <= (fpos_reg == PW'(FILTER_SIZE - 1)) ?
                                            '0 : fpos_reg + PW'(1);
                                    end
                                end
                            end
                        end
                        rshm_pkg::REQ_FAULT: begin
                            latch_reg  <= 1'b1;
                            health_reg <= rshm_pkg::H_FAULTED;
                            start_reg  <= c_reg.now;
                            fhist_reg  <= '0;
                            uhist_reg  <= '0;
                            fill_reg   <= '0;
                            streak_reg <= '0;
                            fpos_reg   <= '0;
                            fval_reg   <= '0;
                            primed_reg <= 1'b0;
                            huse_reg   <= 1'b0;
                            for (int i = 0; i < FILTER_SIZE; i++) fstore_reg[i] <= '0;
                        end
                        rshm_pkg::REQ_RECOVER: begin
                            latch_reg  <= 1'b0;
                            health_reg <= rshm_pkg::H_HEALTHY;
                        end
                        rshm_pkg::REQ_PAUSE: begin
                            start_reg <= start_reg + c_reg.paused;
                            if (hfresh_reg) lfresh_reg <= lfresh_reg + c_reg.paused;
                            if (huse_reg)   luse_reg   <= luse_reg + c_reg.paused;
                        end
                        rshm_pkg::REQ_RESTART: begin
                            health_reg <= rshm_pkg::H_STARTING;
                            start_reg  <= c_reg.now;
                            lfresh_reg <= c_reg.now;
                            luse_reg   <= c_reg.now;
                            lstamp_reg <= '0;
                            hfresh_reg <= 1'b0;
                            huse_reg   <= 1'b0;
                            hstamp_reg <= 1'b0;
                            latch_reg  <= 1'b0;
                            fhist_reg  <= '0;
                            uhist_reg  <= '0;
                            fill_reg   <= '0;
                            streak_reg <= '0;
                            fpos_reg   <= '0;
                            fval_reg   <= '0;
                            primed_reg <= 1'b0;
                            for (int i = 0; i < FILTER_SIZE; i++) fstore_reg[i] <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                rshm_pkg::BK_FILT: begin
                    // One store entry per cycle: running sum, minimum and maximum.
                    if (o_use_reg && idx_reg != IW'(FILTER_SIZE)) begin
                        sum_reg <= sum_reg + SW'(fstore_reg[idx_reg[PW-1:0]]);
                        if (fstore_reg[idx_reg[PW-1:0]] < mn_reg)
                            mn_reg <= fstore_reg[idx_reg[PW-1:0]];
                        if (fstore_reg[idx_reg[PW-1:0]] > mx_reg)
                            mx_reg <= fstore_reg[idx_reg[PW-1:0]];
                        idx_reg <= idx_reg + IW'(1);
                    end else begin
                        if (o_use_reg) fval_reg <= trim_prod[KS +: 16];
                        rem_reg    <= '0;
                        quo_reg    <= '0;
                        dcnt_reg   <= 6'(DW);
                        dsel_reg   <= 2'd1;
                        num_reg    <= DW'(RW'(fones) * RW'(100));
                        rnum_u_reg <= RW'(uones) * RW'(100);
                    end
                end
                rshm_pkg::BK_DIV: begin
                    if (dcnt_reg != 6'd0) begin
                        if (rem_sh >= {1'b0, div_den}) begin
                            rem_reg <= DW'(rem_sh - {1'b0, div_den});
                            quo_reg <= {quo_reg[DW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh[DW-1:0];
                            quo_reg <= {quo_reg[DW-2:0], 1'b0};
                        end
                        num_reg  <= {num_reg[DW-2:0], 1'b0};
                        dcnt_reg <= dcnt_reg - 6'd1;
                    end else begin
                        logic [6:0] r;
                        r = (fill_reg == '0) ? 7'd0 :
                            (quo_reg > DW'(100)) ? 7'd100 : quo_reg[6:0];
                        case (dsel_reg)
                            2'd1:    fr_reg <= r;
                            default: ur_reg <= r;
                        endcase
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        dcnt_reg <= 6'(DW);
                        num_reg  <= DW'(rnum_u_reg);
                        dsel_reg <= dsel_reg + 2'd1;
                    end
                end
                rshm_pkg::BK_DONE: begin
                    o_valid_reg      <= 1'b1;
                    m_declare_fault  <= latch_reg ? 1'b0 :
                        (!hfresh_reg ? ((c_reg.now - start_reg) >= grace)
                                     : ((c_reg.now - lfresh_reg) >= fresh_to));
                    m_recovery_ok    <= latch_reg && (fill_reg >= FW'(WINDOW_SIZE)) &&
                        huse_reg && ({{(5-FW+1){1'b0}}, fones} >= {1'b0, fresh_min}) &&
                        ({{(5-FW+1){1'b0}}, uones} >= {1'b0, use_min}) &&
                        (streak_reg >= streak_min) && (age_use <= rec_age);
                    m_output_ok      <= !latch_reg && primed_reg && huse_reg &&
                        (age_use <= out_age);
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid            = o_valid_reg;
    assign m_fresh_frame      = o_fresh_reg;
    assign m_sensor_restarted = o_rst_reg;
    assign m_measurement_ok   = o_ok_reg;
    assign m_usable           = o_use_reg;
    assign m_filtered_mm      = fval_reg;
    assign m_health_state     = health_reg;
    assign m_fresh_rate_pct   = fr_reg;
    assign m_usable_rate_pct  = ur_reg;
    assign m_usable_run       = streak_reg;
endmodule

// ----- rtl/range_sensor_health_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// Range sensor health monitor unit
// Tracks sensor freshness, usable samples, a trimmed-mean filter and health.
// ----------------------------------------------------------------------------
//  Channel  Prefix  Direction  Moves
//  input    s_      in         one event request per handshake
//  result   m_      out        one result request per event
//  config   cfg_    in         register index and write data
//
// From taking a request off the queue to a valid result, the back part takes
// it, applies it, walks the filter store and forms the mean by reciprocal
// multiplication (the walk and the mean are skipped when the sample is not
// usable), runs two restoring divider passes for the rates, and posts the
// result. The next request is taken the cycle after the result is accepted;
// on an idle unit a request first passes the front register and the queue.
// Reset is synchronous and active low; registers return to their defaults.
// The front part keeps accepting requests into a two-entry queue, until it
// is full, while the back part works or while a result waits for m_ready.
module range_sensor_health_monitor_unit #(
    parameter int WINDOW_SIZE = 16,
    parameter int FILTER_SIZE = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_now_ms,
    input  logic [31:0] s_sensor_time_ms,
    input  logic [15:0] s_meas_status,
    input  logic [31:0] s_raw_distance_mm,
    input  logic [31:0] s_paused_ms,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_fresh_frame,
    output logic        m_sensor_restarted,
    output logic        m_measurement_ok,
    output logic        m_usable,
    output logic [15:0] m_filtered_mm,
    output logic [2:0]  m_health_state,
    output logic        m_declare_fault,
    output logic        m_recovery_ok,
    output logic        m_output_ok,
    output logic [6:0]  m_fresh_rate_pct,
    output logic [6:0]  m_usable_rate_pct,
    output logic [7:0]  m_usable_run
);
    logic [15:0] max_dist_reg;
    logic [31:0] grace_reg, fresh_to_reg, rec_age_reg, out_age_reg;
    logic [4:0]  fresh_min_reg, use_min_reg;
    logic [7:0]  streak_min_reg;

    logic           q_push, q_full, q_pop, q_ne;
    rshm_pkg::cmd_t q_in, q_out;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg   <= 16'd4000;
            grace_reg      <= 32'd1000;
            fresh_to_reg   <= 32'd500;
            fresh_min_reg  <= 5'd12;
            use_min_reg    <= 5'd10;
            streak_min_reg <= 8'd5;
            rec_age_reg    <= 32'd200;
            out_age_reg    <= 32'd200;
        end else if (cfg_valid) begin
            case (cfg_index)
                rshm_pkg::CFG_MAX_DIST:  max_dist_reg   <= cfg_data[15:0];
                rshm_pkg::CFG_GRACE:     grace_reg      <= cfg_data;
                rshm_pkg::CFG_FRESH_TO:  fresh_to_reg   <= cfg_data;
                rshm_pkg::CFG_FRESH_MIN: fresh_min_reg  <= cfg_data[4:0];
                rshm_pkg::CFG_USE_MIN:   use_min_reg    <= cfg_data[4:0];
                rshm_pkg::CFG_STREAK:    streak_min_reg <= cfg_data[7:0];
                rshm_pkg::CFG_REC_AGE:   rec_age_reg    <= cfg_data;
                rshm_pkg::CFG_OUT_AGE:   out_age_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    rshm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_now_ms,
        .s_sensor_time_ms, .s_meas_status, .s_raw_distance_mm, .s_paused_ms,
        .max_distance(max_dist_reg), .q_push, .q_data(q_in), .q_full
    );

    rshm_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
    );

    rshm_back #(.WINDOW_SIZE(WINDOW_SIZE), .FILTER_SIZE(FILTER_SIZE)) u_back (
        .aclk, .aresetn, .q_not_empty(q_ne), .q_data(q_out), .q_pop,
        .grace(grace_reg), .fresh_to(fresh_to_reg), .fresh_min(fresh_min_reg),
        .use_min(use_min_reg), .streak_min(streak_min_reg), .rec_age(rec_age_reg),
        .out_age(out_age_reg), .m_valid, .m_ready, .m_fresh_frame, .m_sensor_restarted,
        .m_measurement_ok, .m_usable, .m_filtered_mm, .m_health_state, .m_declare_fault,
        .m_recovery_ok, .m_output_ok, .m_fresh_rate_pct, .m_usable_rate_pct, .m_usable_run
    );

`ifndef SYNTHESIS
    // The queue is never pushed when full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push) else $error("queue overflow");
    // A held result is not replaced before it is taken.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // Rates never exceed one hundred percent.
    a_rate_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fresh_rate_pct <= 7'd100 && m_usable_rate_pct <= 7'd100))
        else $error("rate above limit");
`endif
endmodule
